// ===== rtl/tlr_pkg.sv =====
// Shared definitions for the tile line rasterizer.
// Holds the default tile coordinate width and the controller/datapath interface types.
package tlr_pkg;

  localparam int unsigned COORD_BITS_DEF = 6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a new segment and set up the first pixel
    logic step;   // advance to the next pixel along the major axis
  } tlr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;   // current pixel is the segment's final one
  } tlr_stat_t;

endpackage

// ===== rtl/tlr_ctrl.sv =====
// Controller for the tile line rasterizer: idle/run sequencing and handshakes.
// Depends on tlr_pkg for the command and status types.
module tlr_ctrl import tlr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tlr_stat_t stat,
  output tlr_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } tlr_state_t;

  tlr_state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_RUN);

  always_comb begin
    cmd.load  = in_valid && in_ready;
    cmd.step  = out_valid && out_ready && !stat.last;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        // drop back to idle once the final word is taken
        if (out_ready && stat.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/tlr_datapath.sv =====
// Datapath for the tile line rasterizer: segment setup and exact incremental stepping.
// Depends on tlr_pkg for the command and status types.
module tlr_datapath import tlr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  tlr_cmd_t              cmd,
  output tlr_stat_t             stat,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned RW = COORD_BITS + 2;

  // setup
  logic [W-1:0] dx, dy, a0, b0, p0, q0, a, b, p, q;
  logic         steep;

  always_comb begin
    dx    = (start_x > end_x) ? start_x - end_x : end_x - start_x;
    dy    = (start_y > end_y) ? start_y - end_y : end_y - start_y;
    steep = dx < dy;
    a0 = steep ? start_y : start_x;
    p0 = steep ? start_x : start_y;
    b0 = steep ? end_y   : end_x;
    q0 = steep ? end_x   : end_y;
    if (a0 > b0) begin
      a = b0; b = a0; p = q0; q = p0;
    end else begin
      a = a0; b = b0; p = p0; q = q0;
    end
  end

  logic [W-1:0]         k_r, k_nxt, b_r, b_nxt, m_r, m_nxt, span_r, span_nxt;
  logic signed [W:0]    delta_r, delta_nxt;
  logic signed [RW-1:0] rem_r, rem_nxt;
  logic                 steep_r, steep_nxt;

  // step: remainder stays in [0, span); |delta| <= span so one correction suffices
  logic signed [RW-1:0] sum, span_ext;

  always_comb begin
    span_ext  = $signed({2'b00, span_r});
    sum       = rem_r + {delta_r[W], delta_r};
    k_nxt     = k_r;
    b_nxt     = b_r;
    m_nxt     = m_r;
    span_nxt  = span_r;
    delta_nxt = delta_r;
    rem_nxt   = rem_r;
    steep_nxt = steep_r;
    if (cmd.load) begin
      k_nxt     = a;
      b_nxt     = b;
      m_nxt     = p;
      span_nxt  = b - a;
      delta_nxt = $signed({1'b0, q}) - $signed({1'b0, p});
      rem_nxt   = '0;
      steep_nxt = steep;
    end else if (cmd.step) begin
      k_nxt = k_r + 1'b1;
      if (sum >= span_ext) begin
        m_nxt   = m_r + 1'b1;
        rem_nxt = sum - span_ext;
      end else if (sum < 0) begin
        m_nxt   = m_r - 1'b1;
        rem_nxt = sum + span_ext;
      end else begin
        rem_nxt = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    b_r     <= b_nxt;
    m_r     <= m_nxt;
    span_r  <= span_nxt;
    delta_r <= delta_nxt;
    rem_r   <= rem_nxt;
    steep_r <= steep_nxt;
  end

  assign stat.last  = (k_r == b_r);
  assign last_pixel = stat.last;
  assign pixel_x    = steep_r ? m_r : k_r;
  assign pixel_y    = steep_r ? k_r : m_r;

endmodule

// ===== rtl/tile_line_rasterizer.sv =====
// Top level of the tile line rasterizer: controller plus datapath.
// Depends on tlr_pkg, tlr_ctrl and tlr_datapath.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_ready, in_start_x/y, in_end_x/y    | segment in
//  out     | out_valid/out_ready, out_pixel_x/y, out_last_pixel | pixels out
//
// A segment with major span s yields s+1 words, one per cycle while out_ready
// is high; the segment is taken in the idle state before its first word, and
// no new segment is taken while words are pending. The pixel stepper (one add
// and two compares per pixel) sets that pace.
// The next segment is taken in the cycle after the last word is accepted.
// Reset (synchronous, active low) returns the controller to idle; out_ready
// low holds the current word in place.
module tile_line_rasterizer import tlr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last_pixel
);

  tlr_cmd_t  cmd;
  tlr_stat_t stat;

  // Sequencing: idle takes a segment, run emits pixels until the last one goes.
  tlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Setup orders endpoints along the major axis; stepping keeps the minor
  // coordinate as quotient plus remainder of the exact interpolation.
  tlr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .stat       (stat),
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .pixel_x    (out_pixel_x),
    .pixel_y    (out_pixel_y),
    .last_pixel (out_last_pixel)
  );

`ifndef SYNTHESIS
  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && !in_ready)
    else $error("segment accepted but no pixel run started");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_pixel |=> in_ready && !out_valid)
    else $error("input not freed after final pixel");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_pixel |=> out_valid)
    else $error("pixel run ended before the final pixel");

  a_never_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input open while a pixel run is active");
`endif

endmodule

// ===== sim/tile_line_rasterizer_test.sv =====
`timescale 1ns / 100ps
// Self-checking regression for tile_line_rasterizer: segments in, pixel words out.
// Depends on tlr_pkg and the tile_line_rasterizer RTL; needs nothing else to run.
module tile_line_rasterizer_test;
  import tlr_pkg::*;

  localparam int unsigned CB          = COORD_BITS_DEF;
  localparam int unsigned TILE_MAX    = (1 << CB) - 1;
  localparam int unsigned RANDOM_SEGS = 352;
  // Watchdog limit far above the slowest legal run, with plenty of slack.
  localparam int unsigned CYCLE_LIMIT = 800_000;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // Holds the expected pixel words of every accepted segment, oldest first.
  class pixel_scoreboard;
    pixel_t      expected_pixels[$];
    int unsigned mismatches;

    // Walk the segment along its major axis and queue one word per step.
    function void note_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      int unsigned dx, dy, a, b, p, q, t, span, k, minor;
      bit          steep;
      pixel_t      px;
      dx    = (sx > ex) ? 32'(sx - ex) : 32'(ex - sx);
      dy    = (sy > ey) ? 32'(sy - ey) : 32'(ey - sy);
      // Equal spans stay shallow: x remains the major axis.
      steep = dx < dy;
      if (steep) begin
        a = 32'(sy); p = 32'(sx); b = 32'(ey); q = 32'(ex);
      end else begin
        a = 32'(sx); p = 32'(sy); b = 32'(ex); q = 32'(ey);
      end
      // Order the endpoints so the major coordinate rises.
      if (a > b) begin
        t = a; a = b; b = t;
        t = p; p = q; q = t;
      end
      span = b - a;
      for (k = a; k <= b; k++) begin
        // Coincident endpoints: single pixel, no division.
        minor   = (span == 0) ? p : (p * (b - k) + q * (k - a)) / span;
        px.x    = steep ? coord_t'(minor) : coord_t'(k);
        px.y    = steep ? coord_t'(k) : coord_t'(minor);
        px.last = (k == b);
        expected_pixels.push_back(px);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel word x=%0d y=%0d last=%0b", got.x, got.y, got.last);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.x !== want.x) begin
        $error("pixel_x: expected %0d, actual %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("pixel_y: expected %0d, actual %0d", want.y, got.y);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_pixel: expected %0b, actual %0b", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_pixels.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_last_pixel;

  // When set, neither side inserts idle cycles.
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;

  pixel_scoreboard pixel_sb = new();

  tile_line_rasterizer #(.COORD_BITS(CB)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

  // 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: drop ready about 17 percent of the time unless calm.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 17);
  end

  // Monitor both channels on the edge; every driven signal changes by NBA, so
  // the values read here are the ones the block saw at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        pixel_sb.note_segment(in_start_x, in_start_y, in_end_x, in_end_y);
      if (out_valid && out_ready)
        pixel_sb.check_pixel('{x: out_pixel_x, y: out_pixel_y, last: out_last_pixel});
    end
  end

  // Watchdog: count cycles and give up at the limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tile_line_rasterizer regression: fail");
    $finish;
  end

  // Present one segment word after a random idle gap and hold it until taken.
  task automatic send_segment(input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender off until every queued pixel word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixel_sb.outstanding() != 0);
  endtask

  // Pick an endpoint near the start; short segments keep the run quick.
  function automatic coord_t near_coord(coord_t base);
    int off;
    off = int'(base) + int'($urandom_range(14)) - 7;
    if (off < 0) off = 0;
    if (off > int'(TILE_MAX)) off = int'(TILE_MAX);
    return coord_t'(off);
  endfunction

  initial begin
    coord_t sx, sy, ex, ey;

    // Hold reset, then release it for good.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coincident endpoints: one pixel each.
    send_segment(0, 0, 0, 0);
    send_segment(63, 63, 63, 63);
    send_segment(17, 42, 17, 42);
    // Full-tile horizontal and vertical runs, both directions.
    send_segment(0, 0, 63, 0);
    send_segment(63, 63, 0, 63);
    send_segment(0, 0, 0, 63);
    send_segment(63, 63, 63, 0);
    // Equal spans stay x-major.
    send_segment(0, 0, 63, 63);
    send_segment(63, 0, 0, 63);
    send_segment(0, 63, 63, 0);
    send_segment(42, 21, 21, 42);
    // One off the diagonal on either side.
    send_segment(0, 0, 62, 63);
    send_segment(0, 0, 63, 62);
    // Endpoints given with the major coordinate falling, then an equal-span case.
    send_segment(40, 60, 10, 2);
    send_segment(60, 40, 3, 10);
    send_segment(21, 42, 42, 21);
    // Span of one along each axis, and a steep segment with a minor span of one.
    send_segment(5, 5, 6, 5);
    send_segment(5, 5, 5, 6);
    send_segment(5, 5, 6, 6);
    send_segment(9, 30, 8, 33);

    // Let the directed words drain before the random part.
    wait_drained();

    for (int i = 0; i < RANDOM_SEGS; i++) begin
      // Stretch with no idling on either side.
      calm = (i >= 120 && i < 200);
      if (i == 250)
        wait_drained();
      sx = coord_t'($urandom_range(TILE_MAX));
      sy = coord_t'($urandom_range(TILE_MAX));
      if ($urandom_range(99) < 65) begin
        ex = near_coord(sx);
        ey = near_coord(sy);
      end else begin
        ex = coord_t'($urandom_range(TILE_MAX));
        ey = coord_t'($urandom_range(TILE_MAX));
      end
      send_segment(sx, sy, ex, ey);
    end
    calm = 1'b0;

    // Drain, then watch a little longer for stray words.
    wait_drained();
    repeat (2 * (TILE_MAX + 1)) @(posedge clk);

    if (pixel_sb.mismatches == 0 && pixel_sb.outstanding() == 0)
      $display("tile_line_rasterizer regression: pass");
    else
      $display("tile_line_rasterizer regression: fail");
    $finish;
  end

endmodule
